### rtl/hds_pkg.sv
// Shared types and constants of the hit distance sorter.
package hds_pkg;

   localparam int MAX_HITS_DEFAULT = 16;
   localparam int KEY_WIDTH        = 32;
   localparam int TAG_WIDTH        = 8;

   // One stored hit record.
   typedef struct packed {
      logic                        valid;
      logic signed [KEY_WIDTH-1:0] key;
      logic        [TAG_WIDTH-1:0] tag;
   } cell_data_type;

   localparam cell_data_type CELL_EMPTY = '{valid: 1'b0, key: '0, tag: '0};

   // What every cell of the chain does this cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DRAIN
   } cell_op_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } sorter_state_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_fire;
      logic batch_end;
      logic full;
      logic rsp_fire;
      logic rsp_last;
   } ctrl_status_type;

   // Commands from the controller to the datapath and the channels.
   typedef struct packed {
      cell_op_type op;
      logic        req_ready;
      logic        rsp_valid;
      logic        overflowed;
   } ctrl_cmd_type;

endpackage

### rtl/hds_if.sv
// Channel interfaces of the hit distance sorter.
interface hds_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] hit_distance;
   logic        [7:0]  hit_tag;
   logic               batch_end;

   modport source (output valid, hit_distance, hit_tag, batch_end, input ready);
   modport sink   (input valid, hit_distance, hit_tag, batch_end, output ready);
   modport monitor (input valid, ready, hit_distance, hit_tag, batch_end);
endinterface

interface hds_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_distance;
   logic        [7:0]  sorted_tag;
   logic               run_last;
   logic               overflowed;

   modport source (output valid, sorted_distance, sorted_tag, run_last, overflowed,
                   input ready);
   modport sink   (input valid, sorted_distance, sorted_tag, run_last, overflowed,
                   output ready);
   modport monitor (input valid, ready, sorted_distance, sorted_tag, run_last, overflowed);
endinterface

### rtl/hds_cell.sv
// One cell of the insertion chain: holds a record, inserts or shifts.
module hds_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  hds_pkg::cell_op_type   op,
   input  hds_pkg::cell_data_type new_rec,
   input  hds_pkg::cell_data_type prev_data,
   input  logic                   prev_greater,
   input  hds_pkg::cell_data_type next_data,
   output hds_pkg::cell_data_type data,
   output logic                   greater
);
   import hds_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in;

   // Empty cells count as greater so that the first empty one takes the record.
   // Equal keys are not greater, which keeps arrival order.
   assign greater = !data_ff.valid || (data_ff.key > new_rec.key);
   assign data    = data_ff;

   always_comb begin
      data_in = data_ff;
      case (op)
         OP_INSERT: begin
            if (greater) begin
               data_in = prev_greater ? prev_data : new_rec;
            end
         end
         OP_DRAIN: begin
            data_in = next_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/hds_ctrl.sv
// Fill/drain controller and batch overflow flag.
module hds_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  hds_pkg::ctrl_status_type status,
   output hds_pkg::ctrl_cmd_type    cmd
);
   import hds_pkg::*;

   sorter_state_type state_ff;
   sorter_state_type state_in;
   logic             overflow_ff;
   logic             overflow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      overflow_in    = overflow_ff;
      cmd.op         = OP_HOLD;
      cmd.req_ready  = 1'b0;
      cmd.rsp_valid  = 1'b0;
      cmd.overflowed = overflow_ff;
      case (state_ff)
         ST_FILL: begin
            cmd.req_ready = 1'b1;
            if (status.req_fire) begin
               // drop the record when the chain is full
               if (status.full) begin
                  overflow_in = 1'b1;
               end else begin
                  cmd.op = OP_INSERT;
               end
               if (status.batch_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            cmd.rsp_valid = 1'b1;
            if (status.rsp_fire) begin
               cmd.op = OP_DRAIN;
               if (status.rsp_last) begin
                  overflow_in = 1'b0;
                  state_in    = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

endmodule

### rtl/hit_distance_sorter_core.sv
// Hit distance sorter: stable ascending sort of one ray's hit records.
//
// Records arrive on req_if (hit_distance, hit_tag, batch_end), one per cycle
// while req_if.ready is high. Each accepted record is placed into a chain of
// MAX_HITS cells kept in ascending signed key order; equal keys keep arrival
// order. Records beyond MAX_HITS are dropped and mark the batch overflowed.
// The transaction with batch_end high closes the batch: in the next cycle the
// smallest record appears on rsp_if, and each accepted rsp transaction shifts
// the chain by one cell, so results follow at one per cycle while rsp_if.ready
// is high. run_last flags the final record; overflowed is set on every result
// of a dropping batch. While a batch drains, req_if.ready stays low, since the
// single cell chain serves both filling and draining.
// If the receiver stalls, the current result holds and the chain waits.
// Reset empties the chain, clears the overflow flag and opens the input.
module hit_distance_sorter_core #(
   parameter int MAX_HITS = hds_pkg::MAX_HITS_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   hds_req_if.sink   req_if,
   hds_rsp_if.source rsp_if
);
   import hds_pkg::*;

   cell_data_type   cell_data    [MAX_HITS];
   logic            cell_greater [MAX_HITS];
   cell_data_type   new_rec;
   ctrl_status_type status;
   ctrl_cmd_type    cmd;

   assign new_rec = '{valid: 1'b1, key: req_if.hit_distance, tag: req_if.hit_tag};

   genvar i;
   generate
      for (i = 0; i < MAX_HITS; i++) begin : g_cell
         cell_data_type prev_data;
         logic          prev_greater;
         cell_data_type next_data;

         if (i == 0) begin : g_first
            assign prev_data    = CELL_EMPTY;
            assign prev_greater = 1'b0;
         end else begin : g_inner
            assign prev_data    = cell_data[i-1];
            assign prev_greater = cell_greater[i-1];
         end

         if (i == MAX_HITS - 1) begin : g_last
            assign next_data = CELL_EMPTY;
         end else begin : g_more
            assign next_data = cell_data[i+1];
         end

         hds_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .op           (cmd.op),
            .new_rec      (new_rec),
            .prev_data    (prev_data),
            .prev_greater (prev_greater),
            .next_data    (next_data),
            .data         (cell_data[i]),
            .greater      (cell_greater[i])
         );
      end
   endgenerate

   assign status.req_fire  = req_if.valid && req_if.ready;
   assign status.batch_end = req_if.batch_end;
   assign status.full      = cell_data[MAX_HITS-1].valid;
   assign status.rsp_fire  = rsp_if.valid && rsp_if.ready;
   assign status.rsp_last  = !cell_data[1].valid;

   hds_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   assign req_if.ready           = cmd.req_ready;
   assign rsp_if.valid           = cmd.rsp_valid;
   assign rsp_if.sorted_distance = cell_data[0].key;
   assign rsp_if.sorted_tag      = cell_data[0].tag;
   assign rsp_if.run_last        = !cell_data[1].valid;
   assign rsp_if.overflowed      = cmd.overflowed;

endmodule

### rtl/hds_checker.sv
// Port-level checks of the hit distance sorter, bound to the top level.
module hds_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_batch_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no intake while a batch drains
   a_no_intake_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open during drain");

   // drain starts right after the closing record
   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_batch_end |=> rsp_valid)
      else $error("no result after batch end");

   // the last result ends the batch
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_run_last |=> !rsp_valid && req_ready)
      else $error("results continue after run_last");

endmodule

bind hit_distance_sorter_core hds_checker u_hds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_batch_end (req_if.batch_end),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_run_last  (rsp_if.run_last)
);
